// ----- rtl/octave_value_noise_2d_unit_assert.svh -----
// assertion macros shared by the octave value noise rtl
`ifndef OCTAVE_VALUE_NOISE_2D_UNIT_ASSERT_SVH
`define OCTAVE_VALUE_NOISE_2D_UNIT_ASSERT_SVH
`ifndef SYNTH
`define OVN_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("ovn assertion failed");
`define OVN_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("ovn assertion failed");
`else
`define OVN_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define OVN_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ----- rtl/ovn_pkg.sv -----
// shared types and constants of the octave value noise unit
package ovn_pkg;

  localparam int GRID_SIZE_DEF = 64;

  localparam int COORD_W     = 6;
  localparam int SEED_W      = 16;
  localparam int OCT_COUNT_W = 3;
  localparam int OCT_BIAS_W  = 5;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;
  localparam logic [CFG_INDEX_W-1:0] CFG_OCTAVE_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OCTAVE_BIAS  = 1'b1;
  localparam logic [OCT_COUNT_W-1:0] OCT_COUNT_RST = 3'd7;
  localparam logic [OCT_BIAS_W-1:0]  OCT_BIAS_RST  = 5'd2;

  // q1.16 octave weights
  localparam int WEIGHT_W = 17;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
  localparam int WDIV_STEP   = 4;
  localparam int WDIV_CYCLES = 5;
  localparam int WQW         = WDIV_STEP * WDIV_CYCLES;

  // weighted sums and final normalizing divide
  localparam int SUMW        = 36;
  localparam int WSUMW       = 20;
  localparam int QDIV_STEP   = 4;
  localparam int QDIV_CYCLES = SEED_W / QDIV_STEP;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    logic [COORD_W-1:0]  coord_x;
    logic [COORD_W-1:0]  coord_y;
    logic [SEED_W-1:0]   seed_value;
  } cmd_t;

endpackage

// ----- rtl/ovn_stream_if.sv -----
// item and result channel interfaces
interface ovn_item_if import ovn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [SEED_W-1:0]  seed_value;
  modport source (output valid, mode, coord_x, coord_y, seed_value, input ready);
  modport sink (input valid, mode, coord_x, coord_y, seed_value, output ready);
endinterface

interface ovn_result_if import ovn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SEED_W-1:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

// ----- rtl/octave_value_noise_2d_unit.sv -----
// top level of the octave value noise unit
// usage:
// - item_in carries one word per item: mode 0 stores seed_value at (coord_x, coord_y),
//   mode 1 queries the normalized octave noise at (coord_x, coord_y)
// - result_out carries one word per query and nothing for seed writes
// - coordinates wrap modulo GRID_SIZE, which must be a power of two
// - cfg_write_en/cfg_index/cfg_data write octave_count (index 0) and octave_bias
//   (index 1); write them only while no item is in flight
// - a word enters a front register, waits in a two-entry command queue, then the back
//   end runs it; seed writes are stored straight from the back end's idle state
// - a query runs, per octave, the seed memory reads (four corners through the single
//   read port, registered data), four multiply/normalize steps and one accumulate,
//   then the normalizing divide and the load of the output register
// - the next octave weight is divided out during the read cycles
// - reset clears the queue, the sequencer and the output valid and loads the register
//   defaults (7 octaves, bias 2); the seed memory is not cleared and must be written
//   before it is queried
// - when result_out stalls the finished word stays in the output register; the back end
//   keeps working on the next query and holds only when its own result is ready
module octave_value_noise_2d_unit import ovn_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ovn_item_if.sink               item_in,
  ovn_result_if.source           result_out
);

  logic [OCT_COUNT_W-1:0] octave_count;
  logic [OCT_BIAS_W-1:0]  octave_bias;

  // front to queue
  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;

  // queue to back end
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= OCT_COUNT_RST;
      octave_bias  <= OCT_BIAS_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_OCTAVE_COUNT: octave_count <= cfg_data[OCT_COUNT_W-1:0];
        CFG_OCTAVE_BIAS:  octave_bias  <= cfg_data[OCT_BIAS_W-1:0];
      endcase
    end
  end

  // accept and classify words
  ovn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item_in   (item_in),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  // decouple front and back
  ovn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  // seed store, octave sum and normalization
  ovn_core #(
    .GRID_SIZE (GRID_SIZE)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .octave_count (octave_count),
    .octave_bias  (octave_bias),
    .cmd_valid    (q_valid),
    .cmd          (q_cmd),
    .cmd_ready    (q_ready),
    .result_out   (result_out)
  );

endmodule

// ----- rtl/ovn_front.sv -----
// front stage: registers incoming words and classifies them as write or query
module ovn_front import ovn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ovn_item_if.sink    item_in,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_ready
);

  assign item_in.ready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (item_in.ready) begin
      cmd_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      cmd.mode       <= item_in.mode ? MODE_QUERY : MODE_WRITE;
      cmd.coord_x    <= item_in.coord_x;
      cmd.coord_y    <= item_in.coord_y;
      cmd.seed_value <= item_in.seed_value;
    end
  end

endmodule

// ----- rtl/ovn_queue.sv -----
// short command queue between front and back
`include "octave_value_noise_2d_unit_assert.svh"
module ovn_queue import ovn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t                   entry [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   push;
  logic                   pop;

  assign push_ready = count != QUEUE_CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  `OVN_ASSERT_IMPLY(a_full_ptrs, clk, rst, count == QUEUE_CNT_W'(QUEUE_DEPTH), wr_ptr == rd_ptr)
  `OVN_ASSERT_IMPLY(a_empty_ptrs, clk, rst, count == '0, wr_ptr == rd_ptr)
  `OVN_ASSERT_NEXT(a_push_count, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

// ----- rtl/ovn_core.sv -----
// back end: seed memory, octave sequencer, weight and normalizing dividers
`include "octave_value_noise_2d_unit_assert.svh"
module ovn_core import ovn_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [OCT_COUNT_W-1:0] octave_count,
  input  logic [OCT_BIAS_W-1:0]  octave_bias,
  input  logic                   cmd_valid,
  input  cmd_t                   cmd,
  output logic                   cmd_ready,
  ovn_result_if.source           result_out
);

  localparam int CW        = $clog2(GRID_SIZE);
  localparam int AW        = 2 * CW;
  localparam int XW        = (CW > COORD_W) ? CW : COORD_W;
  localparam int PW        = CW + 1;
  localparam int TOPW      = SEED_W + PW;
  localparam int NUMW      = SEED_W + 2 * PW;
  localparam int SHW       = $clog2(2 * CW + 1);
  localparam int OCT_LIMIT = CW + 1;
  localparam int DEPTH     = GRID_SIZE * GRID_SIZE;
  localparam logic [2:0] READ_LAST = 3'(WDIV_CYCLES - 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_READ  = 9'b000000010,
    S_MUL1  = 9'b000000100,
    S_SUM   = 9'b000001000,
    S_MUL2  = 9'b000010000,
    S_NORM  = 9'b000100000,
    S_ACCUM = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t                 state;
  logic [CW-1:0]          x, y;
  logic [2:0]             k, n_oct;
  logic [OCT_BIAS_W-1:0]  bias_r;
  logic [WEIGHT_W-1:0]    weight;
  logic [WQW-1:0]         wq, wq_next;
  logic [OCT_BIAS_W-1:0]  wrem, wrem_next;
  logic [SUMW-1:0]        sum, sum_next;
  logic [WSUMW-1:0]       wsum;
  logic [2:0]             rd_cnt;
  logic [SEED_W-1:0]      smp [4];
  logic [TOPW-1:0]        pa, pb, pc, pd, top, bot;
  logic [NUMW-1:0]        pe, pf, ef;
  logic [SEED_W-1:0]      val;
  logic [SEED_W-1:0]      dq, dq_next;
  logic [WSUMW-1:0]       drem, drem_next;
  logic [1:0]             dcnt;
  logic                   out_valid;
  logic [SEED_W-1:0]      out_value;
  logic                   out_free;

  logic [XW-1:0]          cx_ext, cy_ext;
  logic [CW-1:0]          cx, cy;
  logic [OCT_COUNT_W-1:0] cnt_eff;
  logic [2:0]             n_oct_start;

  logic [PW-1:0]          pitch, dxc, dyc, x2_sum, y2_sum;
  logic [CW-1:0]          fmask, dx, dy, x1, y1, x2, y2;
  logic [SHW-1:0]         nshift;

  logic                   mem_we;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [SEED_W-1:0]      rd_data;
  logic [SEED_W-1:0]      seed_mem [DEPTH];

  // command coordinates reduced modulo the grid
  assign cx_ext = XW'(cmd.coord_x);
  assign cy_ext = XW'(cmd.coord_y);
  assign cx     = cx_ext[CW-1:0];
  assign cy     = cy_ext[CW-1:0];

  assign cnt_eff     = (octave_count == '0) ? 3'd1 : octave_count;
  assign n_oct_start = (int'(cnt_eff) > OCT_LIMIT) ? 3'(OCT_LIMIT) : cnt_eff;

  assign cmd_ready = (state == S_IDLE);
  assign mem_we    = cmd_ready && cmd_valid && (cmd.mode == MODE_WRITE);
  assign wr_addr   = {cy, cx};

  // lattice geometry of the current octave
  assign pitch  = PW'(GRID_SIZE) >> k;
  assign fmask  = CW'(pitch - PW'(1));
  assign dx     = x & fmask;
  assign dy     = y & fmask;
  assign x1     = x & ~fmask;
  assign y1     = y & ~fmask;
  assign x2_sum = PW'(x1) + pitch;
  assign y2_sum = PW'(y1) + pitch;
  assign x2     = x2_sum[CW-1:0];
  assign y2     = y2_sum[CW-1:0];
  assign dxc    = pitch - PW'(dx);
  assign dyc    = pitch - PW'(dy);
  assign nshift = SHW'(2 * CW) - SHW'({k, 1'b0});
  assign ef     = pe + pf;

  always_comb begin
    case (rd_cnt[1:0])
      2'd0:    rd_addr = {y1, x1};
      2'd1:    rd_addr = {y1, x2};
      2'd2:    rd_addr = {y2, x1};
      default: rd_addr = {y2, x2};
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seed_mem[wr_addr] <= cmd.seed_value;
    end
    rd_data <= seed_mem[rd_addr];
  end

  // next weight, four quotient bits per cycle
  always_comb begin : wdiv
    logic [OCT_BIAS_W:0] wt;
    wq_next   = wq;
    wrem_next = wrem;
    wt        = '0;
    for (int i = 0; i < WDIV_STEP; i++) begin
      wt      = {wrem_next, wq_next[WQW-1]};
      wq_next = {wq_next[WQW-2:0], 1'b0};
      if (wt >= {1'b0, bias_r}) begin
        wrem_next  = OCT_BIAS_W'(wt - {1'b0, bias_r});
        wq_next[0] = 1'b1;
      end else begin
        wrem_next = wt[OCT_BIAS_W-1:0];
      end
    end
  end

  // weighted sum over weight sum, four quotient bits per cycle
  always_comb begin : qdiv
    logic [WSUMW:0] qt;
    dq_next   = dq;
    drem_next = drem;
    qt        = '0;
    for (int i = 0; i < QDIV_STEP; i++) begin
      qt      = {drem_next, dq_next[SEED_W-1]};
      dq_next = {dq_next[SEED_W-2:0], 1'b0};
      if (qt >= {1'b0, wsum}) begin
        drem_next  = WSUMW'(qt - {1'b0, wsum});
        dq_next[0] = 1'b1;
      end else begin
        drem_next = qt[WSUMW-1:0];
      end
    end
  end

  assign sum_next = sum + SUMW'(val) * SUMW'(weight);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd.mode == MODE_QUERY) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (rd_cnt == READ_LAST) begin
            state <= S_MUL1;
          end
        end
        S_MUL1:  state <= S_SUM;
        S_SUM:   state <= S_MUL2;
        S_MUL2:  state <= S_NORM;
        S_NORM:  state <= S_ACCUM;
        S_ACCUM: state <= (k + 3'd1 == n_oct) ? S_DIV : S_READ;
        S_DIV: begin
          if (dcnt == 2'(QDIV_CYCLES - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        x      <= cx;
        y      <= cy;
        k      <= '0;
        n_oct  <= n_oct_start;
        bias_r <= (octave_bias == '0) ? OCT_BIAS_W'(1) : octave_bias;
        weight <= WEIGHT_ONE;
        wq     <= WQW'(WEIGHT_ONE);
        wrem   <= '0;
        sum    <= '0;
        wsum   <= '0;
        rd_cnt <= '0;
      end
      S_READ: begin
        wq     <= wq_next;
        wrem   <= wrem_next;
        rd_cnt <= rd_cnt + 3'd1;
        if (rd_cnt != '0) begin
          smp[2'(rd_cnt - 3'd1)] <= rd_data;
        end
      end
      S_MUL1: begin
        pa <= TOPW'(dxc) * TOPW'(smp[0]);
        pb <= TOPW'(dx) * TOPW'(smp[1]);
        pc <= TOPW'(dxc) * TOPW'(smp[2]);
        pd <= TOPW'(dx) * TOPW'(smp[3]);
      end
      S_SUM: begin
        top <= pa + pb;
        bot <= pc + pd;
      end
      S_MUL2: begin
        pe <= NUMW'(dyc) * NUMW'(top);
        pf <= NUMW'(dy) * NUMW'(bot);
      end
      S_NORM: begin
        val <= SEED_W'(ef >> nshift);
      end
      S_ACCUM: begin
        sum    <= sum_next;
        wsum   <= wsum + WSUMW'(weight);
        weight <= wq[WEIGHT_W-1:0];
        wq     <= WQW'(wq[WEIGHT_W-1:0]);
        wrem   <= '0;
        k      <= k + 3'd1;
        rd_cnt <= '0;
        drem   <= sum_next[SUMW-1:SEED_W];
        dq     <= sum_next[SEED_W-1:0];
        dcnt   <= '0;
      end
      S_DIV: begin
        dq   <= dq_next;
        drem <= drem_next;
        dcnt <= dcnt + 2'd1;
      end
      S_DONE: begin
        if (out_free) begin
          out_value <= dq;
        end
      end
    endcase
  end

  // output register
  assign out_free = !out_valid || result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.noise_value = out_value;

  `OVN_ASSERT_IMPLY(a_div_nonzero, clk, rst, state == S_DIV, wsum != '0)
  `OVN_ASSERT_IMPLY(a_div_rem, clk, rst, state == S_DIV, drem < wsum)
  `OVN_ASSERT_IMPLY(a_oct_range, clk, rst, state == S_READ, k < n_oct)

endmodule
